@@ sv/pump_runtime_limiter_core_assert.svh @@
// assertion macros for the pump runtime limiter
`ifndef PUMP_RUNTIME_LIMITER_CORE_ASSERT_SVH
`define PUMP_RUNTIME_LIMITER_CORE_ASSERT_SVH

// same-cycle implication
`define PRL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pump runtime limiter check failed");

// next-cycle implication
`define PRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pump runtime limiter check failed");

`endif

@@ sv/prl_pkg.sv @@
// types, codes and reset constants of the pump runtime limiter
package prl_pkg;

	localparam int OP_W   = 2;
	localparam int TIME_W = 32;
	localparam int EV_W   = 3;
	localparam int CIDX_W = 2;

	localparam logic [TIME_W-1:0] MAX_RUN_RST    = TIME_W'(60000);
	localparam logic [TIME_W-1:0] MAX_DAY_RST    = TIME_W'(600000);
	localparam logic [TIME_W-1:0] DAY_LENGTH_RST = TIME_W'(24 * 60 * 60 * 1000);

	typedef enum logic [OP_W-1:0] {
		OP_CHECK = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2
	} op_t;

	typedef enum logic [EV_W-1:0] {
		EV_NONE       = 3'd0,
		EV_STARTED    = 3'd1,
		EV_REFUSED    = 3'd2,
		EV_STOP_REQ   = 3'd3,
		EV_STOP_LIMIT = 3'd4
	} event_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_MAX_RUN    = 2'd0,
		CFG_MAX_DAY    = 2'd1,
		CFG_DAY_LENGTH = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] max_run_ms;
		logic [TIME_W-1:0] max_day_ms;
		logic [TIME_W-1:0] day_length_ms;
	} cfg_t;

	typedef struct packed {
		logic              pump_running;
		logic [TIME_W-1:0] run_start_time;
		logic              run_start_valid;
		logic [TIME_W-1:0] day_total;
		logic [TIME_W-1:0] day_window_start;
	} pstate_t;

endpackage

@@ sv/prl_step.sv @@
// next-state and event logic for one transaction
module prl_step (
	input  logic [prl_pkg::OP_W-1:0]   op,
	input  logic [prl_pkg::TIME_W-1:0] now,
	input  prl_pkg::cfg_t              cfg,
	input  prl_pkg::pstate_t           cur,
	output prl_pkg::pstate_t           nxt,
	output prl_pkg::event_t            ev
);
	import prl_pkg::*;

	logic [TIME_W-1:0] run_base;
	logic [TIME_W-1:0] run_len;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] charged;
	logic [TIME_W-1:0] win_len;
	logic              day_over;
	pstate_t           tmp;

	assign run_base = cur.run_start_valid ? cur.run_start_time : now;
	assign run_len  = now - run_base;
	assign sum      = {1'b0, cur.day_total} + {1'b0, run_len};
	assign charged  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	assign win_len  = now - cur.day_window_start;
	assign day_over = win_len > cfg.day_length_ms;

	always_comb begin
		tmp = cur;
		ev  = EV_NONE;
		case (op_t'(op))
			OP_START: begin
				if (cur.day_total >= cfg.max_day_ms) begin
					tmp.pump_running = 1'b0;
					ev = EV_REFUSED;
				end else begin
					tmp.run_start_time  = now;
					tmp.run_start_valid = 1'b1;
					tmp.pump_running    = 1'b1;
					ev = EV_STARTED;
				end
			end
			OP_STOP: begin
				if (cur.pump_running && cur.run_start_valid) begin
					tmp.day_total = charged;
				end
				tmp.run_start_valid = 1'b0;
				tmp.pump_running    = 1'b0;
				ev = EV_STOP_REQ;
			end
			OP_CHECK: begin
				if (cur.pump_running) begin
					tmp.run_start_time  = run_base;
					tmp.run_start_valid = 1'b1;
					if (run_len > cfg.max_run_ms) begin
						tmp.day_total       = charged;
						tmp.run_start_valid = 1'b0;
						tmp.pump_running    = 1'b0;
						ev = EV_STOP_LIMIT;
					end
				end
				if (day_over) begin
					tmp.day_window_start = now;
					tmp.day_total        = '0;
				end
			end
			default: begin
				tmp = cur;
			end
		endcase
		nxt = tmp;
	end

endmodule

@@ sv/pump_runtime_limiter_core.sv @@
// top level of the pump runtime limiter
// an accepted transaction passes the input stage, then prl_step and the result stage
// throughput: one per cycle unless stalled, set by the single state-update stage
// a full input stage and a waiting result stall input only when out_ready is low
// reset: arst_n clears control and run state and loads the default limits
module pump_runtime_limiter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [prl_pkg::OP_W-1:0]      operation,
	input  logic [prl_pkg::TIME_W-1:0]    now_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          pump_drive,
	output logic [prl_pkg::EV_W-1:0]      event_code,
	output logic [prl_pkg::TIME_W-1:0]    used_today_ms,
	input  logic                          cfg_we,
	input  logic [prl_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [prl_pkg::TIME_W-1:0]    cfg_data
);
	import prl_pkg::*;

	cfg_t              cfg_q;
	pstate_t           pst_q;
	pstate_t           pst_nxt;
	event_t            ev_nxt;
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [TIME_W-1:0] now_s1;
	logic              out_valid_q;
	logic              pump_drive_q;
	logic [EV_W-1:0]   event_code_q;
	logic [TIME_W-1:0] used_today_q;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_run_ms    <= MAX_RUN_RST;
			cfg_q.max_day_ms    <= MAX_DAY_RST;
			cfg_q.day_length_ms <= DAY_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MAX_RUN:    cfg_q.max_run_ms    <= cfg_data;
				CFG_MAX_DAY:    cfg_q.max_day_ms    <= cfg_data;
				CFG_DAY_LENGTH: cfg_q.day_length_ms <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= operation;
			now_s1 <= now_ms;
		end
	end

	prl_step u_step (
		.op  (op_s1),
		.now (now_s1),
		.cfg (cfg_q),
		.cur (pst_q),
		.nxt (pst_nxt),
		.ev  (ev_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pst_q <= '0;
		end else if (advance) begin
			pst_q <= pst_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pump_drive_q <= pst_nxt.pump_running;
			event_code_q <= ev_nxt;
			used_today_q <= pst_nxt.day_total;
		end
	end

	assign out_valid     = out_valid_q;
	assign pump_drive    = pump_drive_q;
	assign event_code    = event_code_q;
	assign used_today_ms = used_today_q;

endmodule

@@ sv/prl_checker.sv @@
// port-level checks of the pump runtime limiter and their binding
`include "pump_runtime_limiter_core_assert.svh"

module prl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       pump_drive,
	input logic [prl_pkg::EV_W-1:0]   event_code,
	input logic [prl_pkg::TIME_W-1:0] used_today_ms
);
	import prl_pkg::*;

	logic [TIME_W+EV_W:0] res_bits;

	assign res_bits = {pump_drive, event_code, used_today_ms};

	// a stalled result transaction holds
	`PRL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(res_bits))

	// a new result follows an accepted input transaction through the input and result stages
	`PRL_ASSERT_IMPL(a_out_latency, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

	// input stalls only behind a waiting result
	`PRL_ASSERT_IMPL(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)

endmodule

bind pump_runtime_limiter_core prl_checker u_prl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.pump_drive    (pump_drive),
	.event_code    (event_code),
	.used_today_ms (used_today_ms)
);

@@ test/pump_runtime_limiter_core_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the pump runtime limiter core: directed table, then random phases
module pump_runtime_limiter_core_test;
	import prl_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 200;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_PRESSURE} idle_mode_t;

	typedef struct {
		logic              drive;
		event_t            ev;
		logic [TIME_W-1:0] used;
	} pump_result_t;

	typedef struct {
		bit                is_cfg;
		cfg_idx_t          idx;
		logic [TIME_W-1:0] data;
		logic [OP_W-1:0]   op;
		bit                typed;
		pump_result_t      res;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic [OP_W-1:0]     operation = '0;
	logic [TIME_W-1:0]   now_ms = '0;
	logic                out_ready = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [TIME_W-1:0]   cfg_data = '0;
	logic                in_ready;
	logic                out_valid;
	logic                pump_drive;
	logic [EV_W-1:0]     event_code;
	logic [TIME_W-1:0]   used_today_ms;

	logic [TIME_W-1:0]   lim_max_run;
	logic [TIME_W-1:0]   lim_max_day;
	logic [TIME_W-1:0]   lim_day_len;
	logic                mdl_running;
	logic                mdl_start_valid;
	logic [TIME_W-1:0]   mdl_start;
	logic [TIME_W-1:0]   mdl_total;
	logic [TIME_W-1:0]   mdl_window;

	pump_result_t        pending_results[$];
	int                  fail_count = 0;
	int                  cycle_count = 0;
	idle_mode_t          idle_mode = IDLE_NONE;
	int                  hold_left = 0;
	bit                  hold_done = 1'b0;
	logic [TIME_W-1:0]   stamp_clock = '0;

	pump_runtime_limiter_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pump_drive    (pump_drive),
		.event_code    (event_code),
		.used_today_ms (used_today_ms),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int send_idle_pct(idle_mode_t m);
		case (m)
			IDLE_SEND: return 81;
			IDLE_BOTH: return 6;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(idle_mode_t m);
		case (m)
			IDLE_RECV: return 81;
			IDLE_BOTH: return 6;
			default:   return 0;
		endcase
	endfunction

	function automatic stim_row_t item_row(logic [OP_W-1:0] op, logic [TIME_W-1:0] now);
		stim_row_t s;
		s.is_cfg = 1'b0;
		s.idx = CFG_MAX_RUN;
		s.data = now;
		s.op = op;
		s.typed = 1'b0;
		s.res.drive = 1'b0;
		s.res.ev = EV_NONE;
		s.res.used = '0;
		return s;
	endfunction

	function automatic stim_row_t typed_row(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
			logic drive, event_t ev, logic [TIME_W-1:0] used);
		stim_row_t s;
		s = item_row(op, now);
		s.typed = 1'b1;
		s.res.drive = drive;
		s.res.ev = ev;
		s.res.used = used;
		return s;
	endfunction

	function automatic stim_row_t cfg_row(cfg_idx_t i, logic [TIME_W-1:0] v);
		stim_row_t s;
		s = item_row(OP_CHECK, v);
		s.is_cfg = 1'b1;
		s.idx = i;
		return s;
	endfunction

	// charge the elapsed run to the day total, saturating, and switch off
	task automatic charge_run(input logic [TIME_W-1:0] now);
		logic [TIME_W:0] sum;
		if (mdl_running && mdl_start_valid) begin
			sum = {1'b0, mdl_total} + {1'b0, now - mdl_start};
			mdl_total = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		end
		mdl_start_valid = 1'b0;
		mdl_running = 1'b0;
	endtask

	task automatic step_pump_model(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
			output pump_result_t r);
		logic [TIME_W-1:0] elapsed;
		event_t ev;
		ev = EV_NONE;
		case (op)
			OP_START: begin
				if (mdl_total >= lim_max_day) begin
					mdl_running = 1'b0;
					ev = EV_REFUSED;
				end else begin
					mdl_start = now;
					mdl_start_valid = 1'b1;
					mdl_running = 1'b1;
					ev = EV_STARTED;
				end
			end
			OP_STOP: begin
				charge_run(now);
				ev = EV_STOP_REQ;
			end
			OP_CHECK: begin
				if (mdl_running) begin
					if (!mdl_start_valid) begin
						mdl_start = now;
						mdl_start_valid = 1'b1;
					end
					elapsed = now - mdl_start;
					if (elapsed > lim_max_run) begin
						charge_run(now);
						ev = EV_STOP_LIMIT;
					end
				end
				elapsed = now - mdl_window;
				if (elapsed > lim_day_len) begin
					mdl_window = now;
					mdl_total = '0;
				end
			end
			default: begin
			end
		endcase
		r.drive = mdl_running;
		r.ev = ev;
		r.used = mdl_total;
	endtask

	task automatic send_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
			output pump_result_t r);
		if ($urandom_range(99) < send_idle_pct(idle_mode)) begin
			@(negedge clk) in_valid <= 1'b0;
			while ($urandom_range(99) < send_idle_pct(idle_mode))
				@(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		now_ms <= now;
		do @(posedge clk); while (!in_ready);
		step_pump_model(op, now, r);
	endtask

	task automatic wait_drained(input int settle);
		@(negedge clk) in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t i, input logic [TIME_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= i;
		cfg_data <= v;
		@(negedge clk) cfg_we <= 1'b0;
		case (i)
			CFG_MAX_RUN:    lim_max_run = v;
			CFG_MAX_DAY:    lim_max_day = v;
			CFG_DAY_LENGTH: lim_day_len = v;
			default: begin
			end
		endcase
	endtask

	task automatic run_random_phase(input idle_mode_t m, input int n,
			input logic [TIME_W-1:0] step_max, input logic [TIME_W-1:0] run_ms,
			input logic [TIME_W-1:0] day_ms, input logic [TIME_W-1:0] len_ms);
		logic [OP_W-1:0] op;
		logic [TIME_W-1:0] now;
		pump_result_t r;
		int pick;
		wait_drained(4);
		write_cfg(CFG_MAX_RUN, run_ms);
		write_cfg(CFG_MAX_DAY, day_ms);
		write_cfg(CFG_DAY_LENGTH, len_ms);
		idle_mode = m;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				op = OP_W'($urandom_range(3));
				now = $urandom();
			end else begin
				pick = $urandom_range(99);
				if (pick < 45)
					op = OP_CHECK;
				else if (pick < 72)
					op = OP_START;
				else if (pick < 95)
					op = OP_STOP;
				else
					op = OP_UNUSED;
				if ($urandom_range(19) == 0)
					stamp_clock += $urandom();
				else
					stamp_clock += $urandom_range(0, step_max);
				now = stamp_clock;
			end
			send_item(op, now, r);
			pending_results.push_back(r);
		end
	endtask

	// receiver side, with one long hold-off in the pressure phase
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (idle_mode == IDLE_PRESSURE && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct(idle_mode));
		end
	end

	always @(posedge clk) begin
		pump_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("transaction with none pending: pump_drive %0d event_code %0d used_today_ms %0d",
					pump_drive, event_code, used_today_ms);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (pump_drive !== exp_r.drive) begin
					$error("pump_drive mismatch: expected %0d, actual %0d", exp_r.drive, pump_drive);
					fail_count++;
				end
				if (event_code !== exp_r.ev) begin
					$error("event_code mismatch: expected %0d, actual %0d", exp_r.ev, event_code);
					fail_count++;
				end
				if (used_today_ms !== exp_r.used) begin
					$error("used_today_ms mismatch: expected %0d, actual %0d",
						exp_r.used, used_today_ms);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		pump_result_t r;
		lim_max_run = MAX_RUN_RST;
		lim_max_day = MAX_DAY_RST;
		lim_day_len = DAY_LENGTH_RST;
		mdl_running = 1'b0;
		mdl_start_valid = 1'b0;
		mdl_start = '0;
		mdl_total = '0;
		mdl_window = '0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		rows.push_back(typed_row(OP_UNUSED, 32'd0, 1'b0, EV_NONE, 32'd0));
		rows.push_back(typed_row(OP_CHECK, 32'd0, 1'b0, EV_NONE, 32'd0));
		rows.push_back(typed_row(OP_STOP, 32'd5, 1'b0, EV_STOP_REQ, 32'd0));
		rows.push_back(typed_row(OP_START, 32'd1000, 1'b1, EV_STARTED, 32'd0));
		rows.push_back(item_row(OP_CHECK, 32'd61000));
		rows.push_back(item_row(OP_CHECK, 32'd61001));
		// run across the timestamp wrap
		rows.push_back(item_row(OP_START, 32'hFFFF_FF00));
		rows.push_back(item_row(OP_STOP, 32'h0000_0100));
		// restart while running is not charged
		rows.push_back(item_row(OP_START, 32'd200));
		rows.push_back(item_row(OP_START, 32'd300));
		rows.push_back(item_row(OP_STOP, 32'd400));
		rows.push_back(cfg_row(CFG_MAX_DAY, 32'd0));
		rows.push_back(item_row(OP_START, 32'd500));
		// refused while running
		rows.push_back(cfg_row(CFG_MAX_DAY, 32'd600000));
		rows.push_back(item_row(OP_START, 32'd1000));
		rows.push_back(cfg_row(CFG_MAX_DAY, 32'd0));
		rows.push_back(item_row(OP_START, 32'd2000));
		// day total saturation
		rows.push_back(cfg_row(CFG_MAX_DAY, 32'hFFFF_FFFF));
		rows.push_back(cfg_row(CFG_MAX_RUN, 32'hFFFF_FFFF));
		rows.push_back(item_row(OP_START, 32'd0));
		rows.push_back(typed_row(OP_STOP, 32'hFFFF_FFFF, 1'b0, EV_STOP_REQ, 32'hFFFF_FFFF));
		// zero day length
		rows.push_back(cfg_row(CFG_DAY_LENGTH, 32'd0));
		rows.push_back(typed_row(OP_CHECK, 32'd7, 1'b0, EV_NONE, 32'd0));
		rows.push_back(item_row(OP_CHECK, 32'd7));
		// run limit and day window in the same check
		rows.push_back(cfg_row(CFG_DAY_LENGTH, 32'd1000));
		rows.push_back(cfg_row(CFG_MAX_RUN, 32'd10));
		rows.push_back(item_row(OP_START, 32'd100));
		rows.push_back(typed_row(OP_CHECK, 32'd2000, 1'b0, EV_STOP_LIMIT, 32'd0));

		foreach (rows[k]) begin
			if (rows[k].is_cfg) begin
				wait_drained(4);
				write_cfg(rows[k].idx, rows[k].data);
			end else begin
				send_item(rows[k].op, rows[k].data, r);
				pending_results.push_back(rows[k].typed ? rows[k].res : r);
			end
		end

		run_random_phase(IDLE_NONE, PHASE_ITEMS, 32'd40, 32'd50, 32'd400, 32'd2000);
		run_random_phase(IDLE_SEND, PHASE_ITEMS, 32'd100, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random_phase(IDLE_RECV, PHASE_ITEMS, 32'd1000, 32'hFFFF_FFFF, 32'd0, 32'd1);
		run_random_phase(IDLE_BOTH, PHASE_ITEMS, 32'd300, $urandom_range(500),
			$urandom_range(3000), $urandom_range(1, 5000));
		run_random_phase(IDLE_PRESSURE, PHASE_ITEMS, 32'h0FFF_FFFF, $urandom(), $urandom(),
			$urandom() | 32'd1);
		run_random_phase(IDLE_NONE, PHASE_ITEMS, 32'd20000, MAX_RUN_RST, MAX_DAY_RST,
			DAY_LENGTH_RST);

		wait_drained(20);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/prl_pkg.sv
sv/prl_step.sv
sv/pump_runtime_limiter_core.sv
sv/prl_checker.sv
test/pump_runtime_limiter_core_test.sv
